// ----- src/dcr_pkg.sv -----
// Package for the disk command register controller.
// Geometry defaults, command and status codes and payload structs.
// No dependencies.
`default_nettype none

package dcr_pkg;

    // Drive geometry, defaults for the top-level parameters
    localparam int SECTORS_PER_TRACK = 64;
    localparam int CYLINDERS         = 153;
    localparam int SURFACES          = 4;
    localparam int SECTOR_BYTES      = 128;

    localparam int OFFSET_W = 23;

    // Bus access codes
    localparam logic OP_READ   = 1'b0;
    localparam logic OP_WRITE  = 1'b1;
    localparam logic PORT_CMD  = 1'b0;
    localparam logic PORT_DATA = 1'b1;

    // Commands
    localparam logic [7:0] CMD_HEARTBEAT   = 8'd1;
    localparam logic [7:0] CMD_SET_SECTOR  = 8'd3;
    localparam logic [7:0] CMD_SET_SURFACE = 8'd4;
    localparam logic [7:0] CMD_SET_TRACK   = 8'd5;
    localparam logic [7:0] CMD_ADDR_HIGH   = 8'd6;
    localparam logic [7:0] CMD_ADDR_LOW    = 8'd7;
    localparam logic [7:0] CMD_READ        = 8'd8;
    localparam logic [7:0] CMD_WRITE       = 8'd9;

    localparam logic [7:0] PING_VALUE = 8'h55;
    localparam logic [7:0] PONG_VALUE = 8'h67;

    // Memory map limits for the buffer address check
    localparam logic [15:0] MEM_TOP    = 16'hFFFF;
    localparam logic [15:0] HOLE_START = 16'h8000;
    localparam logic [15:0] HOLE_END   = 16'h9000;

    // Status codes
    localparam logic [7:0] ST_OK          = 8'd0;
    localparam logic [7:0] ST_BAD_SECTOR  = 8'd1;
    localparam logic [7:0] ST_BAD_TRACK   = 8'd2;
    localparam logic [7:0] ST_BAD_SURFACE = 8'd3;
    localparam logic [7:0] ST_BAD_ADDR    = 8'd4;

    // Config register indexes
    localparam logic CFG_DEVICE_PRESENT = 1'b0;
    localparam logic CFG_ABSENT_VALUE   = 1'b1;

    localparam logic [7:0] ABSENT_RESET = 8'hFF;

    typedef struct packed {
        logic       operation;
        logic       port_select;
        logic [7:0] write_data;
    } item_t;

    typedef struct packed {
        logic [7:0]          read_data;
        logic                transfer_start;
        logic                transfer_direction;
        logic [OFFSET_W-1:0] disk_byte_offset;
        logic [15:0]         memory_address;
    } result_t;

    typedef struct packed {
        logic       device_present;
        logic [7:0] absent_read_value;
    } cfg_t;

endpackage

`default_nettype wire

// ----- src/dcr_in_if.sv -----
// Input channel: one bus access per transfer.
// Depends on nothing.
`default_nettype none

interface dcr_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic       port_select;
    logic [7:0] write_data;

    modport source (output valid, output operation, output port_select, output write_data,
                    input ready);
    modport sink   (input valid, input operation, input port_select, input write_data,
                    output ready);
endinterface

`default_nettype wire

// ----- src/dcr_out_if.sv -----
// Result channel: read data and transfer request per access.
// Depends on nothing.
`default_nettype none

interface dcr_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic        transfer_start;
    logic        transfer_direction;
    logic [22:0] disk_byte_offset;
    logic [15:0] memory_address;

    modport source (output valid, output read_data, output transfer_start,
                    output transfer_direction, output disk_byte_offset,
                    output memory_address, input ready);
    modport sink   (input valid, input read_data, input transfer_start,
                    input transfer_direction, input disk_byte_offset,
                    input memory_address, output ready);
endinterface

`default_nettype wire

// ----- src/dcr_cfg_if.sv -----
// Configuration write channel: register index and data.
// Depends on nothing.
`default_nettype none

interface dcr_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- src/dcr_core.sv -----
// Register file and command decode of the disk controller.
// Uses dcr_pkg for codes, geometry defaults and payload structs.
`default_nettype none

module dcr_core
#(
    parameter int SECTORS_PER_TRACK = dcr_pkg::SECTORS_PER_TRACK,
    parameter int CYLINDERS         = dcr_pkg::CYLINDERS,
    parameter int SURFACES          = dcr_pkg::SURFACES,
    parameter int SECTOR_BYTES      = dcr_pkg::SECTOR_BYTES
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire dcr_pkg::item_t  item,
    input  wire dcr_pkg::cfg_t   cfg,
    output dcr_pkg::result_t     result
);

    // Limits for the register checks
    localparam logic [7:0]  SECTOR_LIMIT  = 8'(SECTORS_PER_TRACK);
    localparam logic [7:0]  TRACK_LIMIT   = 8'(CYLINDERS);
    localparam logic [7:0]  SURFACE_LIMIT = 8'(SURFACES);
    localparam logic [15:0] ADDR_TOP      = 16'(int'(dcr_pkg::MEM_TOP) - SECTOR_BYTES);
    localparam logic [15:0] HOLE_LOW      = 16'(int'(dcr_pkg::HOLE_START) - SECTOR_BYTES);

    // Byte strides per register, kept modulo the offset width
    localparam longint unsigned SECTOR_STRIDE  = longint'(SECTOR_BYTES);
    localparam longint unsigned SURFACE_STRIDE =
        longint'(SECTORS_PER_TRACK) * longint'(SECTOR_BYTES);
    localparam longint unsigned TRACK_STRIDE   =
        longint'(SURFACES) * longint'(SECTORS_PER_TRACK) * longint'(SECTOR_BYTES);

    localparam logic [dcr_pkg::OFFSET_W-1:0] K_SECTOR  = (dcr_pkg::OFFSET_W)'(SECTOR_STRIDE);
    localparam logic [dcr_pkg::OFFSET_W-1:0] K_SURFACE = (dcr_pkg::OFFSET_W)'(SURFACE_STRIDE);
    localparam logic [dcr_pkg::OFFSET_W-1:0] K_TRACK   = (dcr_pkg::OFFSET_W)'(TRACK_STRIDE);

    logic [7:0]  last_command_reg, last_command_next;
    logic [7:0]  data_byte_reg, data_byte_next;
    logic [7:0]  sector_reg, sector_next;
    logic [7:0]  surface_reg, surface_next;
    logic [7:0]  track_reg, track_next;
    logic [15:0] buffer_address_reg, buffer_address_next;

    // Offset contribution of each geometry register, updated when it is loaded
    logic [dcr_pkg::OFFSET_W-1:0] sector_term_reg, sector_term_next;
    logic [dcr_pkg::OFFSET_W-1:0] surface_term_reg, surface_term_next;
    logic [dcr_pkg::OFFSET_W-1:0] track_term_reg, track_term_next;

    logic [dcr_pkg::OFFSET_W+7:0] scaled_sector;
    logic [dcr_pkg::OFFSET_W+7:0] scaled_surface;
    logic [dcr_pkg::OFFSET_W+7:0] scaled_track;
    logic [7:0]                   status;
    logic [dcr_pkg::OFFSET_W-1:0] offset_sum;

    assign scaled_sector  = (dcr_pkg::OFFSET_W+8)'(data_byte_reg)
                          * (dcr_pkg::OFFSET_W+8)'(K_SECTOR);
    assign scaled_surface = (dcr_pkg::OFFSET_W+8)'(data_byte_reg)
                          * (dcr_pkg::OFFSET_W+8)'(K_SURFACE);
    assign scaled_track   = (dcr_pkg::OFFSET_W+8)'(data_byte_reg)
                          * (dcr_pkg::OFFSET_W+8)'(K_TRACK);

    assign offset_sum = sector_term_reg + surface_term_reg + track_term_reg;

    always_comb
    begin
        if (sector_reg >= SECTOR_LIMIT)
        begin
            status = dcr_pkg::ST_BAD_SECTOR;
        end
        else if (track_reg >= TRACK_LIMIT)
        begin
            status = dcr_pkg::ST_BAD_TRACK;
        end
        else if (surface_reg >= SURFACE_LIMIT)
        begin
            status = dcr_pkg::ST_BAD_SURFACE;
        end
        else if ((buffer_address_reg > ADDR_TOP) ||
                 ((buffer_address_reg > HOLE_LOW) &&
                  (buffer_address_reg < dcr_pkg::HOLE_END)))
        begin
            // beyond the top of memory, or overlapping the I/O hole
            status = dcr_pkg::ST_BAD_ADDR;
        end
        else
        begin
            status = dcr_pkg::ST_OK;
        end
    end

    always_comb
    begin
        last_command_next   = last_command_reg;
        data_byte_next      = data_byte_reg;
        sector_next         = sector_reg;
        surface_next        = surface_reg;
        track_next          = track_reg;
        buffer_address_next = buffer_address_reg;
        sector_term_next    = sector_term_reg;
        surface_term_next   = surface_term_reg;
        track_term_next     = track_term_reg;
        result              = '0;

        if (!cfg.device_present)
        begin
            result.read_data = (item.operation == dcr_pkg::OP_WRITE) ? 8'h00
                                                                     : cfg.absent_read_value;
        end
        else if (item.operation == dcr_pkg::OP_READ)
        begin
            result.read_data = (item.port_select == dcr_pkg::PORT_DATA) ? data_byte_reg
                                                                        : last_command_reg;
        end
        else if (item.port_select == dcr_pkg::PORT_DATA)
        begin
            data_byte_next = item.write_data;
        end
        else
        begin
            last_command_next = item.write_data;
            case (item.write_data)
                dcr_pkg::CMD_HEARTBEAT:
                begin
                    if (data_byte_reg == dcr_pkg::PING_VALUE)
                    begin
                        data_byte_next = dcr_pkg::PONG_VALUE;
                    end
                end
                dcr_pkg::CMD_SET_SECTOR:
                begin
                    sector_next      = data_byte_reg;
                    sector_term_next = scaled_sector[dcr_pkg::OFFSET_W-1:0];
                end
                dcr_pkg::CMD_SET_SURFACE:
                begin
                    surface_next      = data_byte_reg;
                    surface_term_next = scaled_surface[dcr_pkg::OFFSET_W-1:0];
                end
                dcr_pkg::CMD_SET_TRACK:
                begin
                    track_next      = data_byte_reg;
                    track_term_next = scaled_track[dcr_pkg::OFFSET_W-1:0];
                end
                dcr_pkg::CMD_ADDR_HIGH:
                begin
                    buffer_address_next = {data_byte_reg, buffer_address_reg[7:0]};
                end
                dcr_pkg::CMD_ADDR_LOW:
                begin
                    buffer_address_next = {buffer_address_reg[15:8], data_byte_reg};
                end
                dcr_pkg::CMD_READ, dcr_pkg::CMD_WRITE:
                begin
                    data_byte_next = status;
                    if (status == dcr_pkg::ST_OK)
                    begin
                        result.transfer_start     = 1'b1;
                        result.transfer_direction = (item.write_data == dcr_pkg::CMD_WRITE);
                        result.disk_byte_offset   = offset_sum;
                        result.memory_address     = buffer_address_reg;
                    end
                end
                default:
                begin
                    // only recorded as last command
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_command_reg   <= '0;
            data_byte_reg      <= '0;
            sector_reg         <= '0;
            surface_reg        <= '0;
            track_reg          <= '0;
            buffer_address_reg <= '0;
            sector_term_reg    <= '0;
            surface_term_reg   <= '0;
            track_term_reg     <= '0;
        end
        else if (accept)
        begin
            last_command_reg   <= last_command_next;
            data_byte_reg      <= data_byte_next;
            sector_reg         <= sector_next;
            surface_reg        <= surface_next;
            track_reg          <= track_next;
            buffer_address_reg <= buffer_address_next;
            sector_term_reg    <= sector_term_next;
            surface_term_reg   <= surface_term_next;
            track_term_reg     <= track_term_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/disk_command_register_controller.sv -----
// Disk command register controller, top level; uses dcr_pkg, the interfaces and dcr_core.
// An accepted access has its result in the output register in the next cycle.
// Throughput: one access per cycle; ready is high while the output register is empty
// or being taken in the same cycle. The offset sum and register checks are combinational.
// Reset (rst_n, asynchronous, active low) clears all drive registers, the device is
// absent and the absent read value is 0xFF.
`default_nettype none

module disk_command_register_controller
#(
    parameter int SECTORS_PER_TRACK = dcr_pkg::SECTORS_PER_TRACK,
    parameter int CYLINDERS         = dcr_pkg::CYLINDERS,
    parameter int SURFACES          = dcr_pkg::SURFACES,
    parameter int SECTOR_BYTES      = dcr_pkg::SECTOR_BYTES
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    dcr_in_if.sink     cmd_in,
    dcr_out_if.source  result_out,
    dcr_cfg_if.sink    cfg
);

    logic              device_present_reg;
    logic [7:0]        absent_read_value_reg;
    logic              out_valid_reg;
    dcr_pkg::result_t  result_reg;

    dcr_pkg::item_t    item;
    dcr_pkg::cfg_t     cfg_state;
    dcr_pkg::result_t  result;
    logic              in_ready;
    logic              accept;

    assign in_ready = !out_valid_reg || result_out.ready;
    assign accept   = cmd_in.valid && in_ready;

    assign cmd_in.ready = in_ready;
    assign cfg.ready    = 1'b1;

    assign item.operation   = cmd_in.operation;
    assign item.port_select = cmd_in.port_select;
    assign item.write_data  = cmd_in.write_data;

    assign cfg_state.device_present    = device_present_reg;
    assign cfg_state.absent_read_value = absent_read_value_reg;

    dcr_core
    #(
        .SECTORS_PER_TRACK (SECTORS_PER_TRACK),
        .CYLINDERS         (CYLINDERS),
        .SURFACES          (SURFACES),
        .SECTOR_BYTES      (SECTOR_BYTES)
    )
    u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .cfg    (cfg_state),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_present_reg    <= 1'b0;
            absent_read_value_reg <= dcr_pkg::ABSENT_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                dcr_pkg::CFG_DEVICE_PRESENT: device_present_reg    <= cfg.data[0];
                dcr_pkg::CFG_ABSENT_VALUE:   absent_read_value_reg <= cfg.data;
                default:                     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= cmd_in.valid;
        end
    end

    // payload register, loaded on each input transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result;
        end
    end

    assign result_out.valid              = out_valid_reg;
    assign result_out.read_data          = result_reg.read_data;
    assign result_out.transfer_start     = result_reg.transfer_start;
    assign result_out.transfer_direction = result_reg.transfer_direction;
    assign result_out.disk_byte_offset   = result_reg.disk_byte_offset;
    assign result_out.memory_address     = result_reg.memory_address;

endmodule

`default_nettype wire
